// ===== src/ldx_pkg.sv =====
// Load executor package: action and update codes, register indexes, beat types.
// Used by the channel interfaces and by cpu_load_instruction_executor.
`default_nettype none

package ldx_pkg;

  // Decoded load actions
  typedef enum logic [3:0] {
    ACT_LD_PAIR = 4'd0,   // pair <- imm16
    ACT_LD_R_N  = 4'd1,   // reg <- imm8
    ACT_LD_R_R  = 4'd2,   // reg <- reg
    ACT_ST_HLD  = 4'd3,   // (HL-) <- A
    ACT_ST_HLI  = 4'd4,   // (HL+) <- A
    ACT_ST_HC   = 4'd5,   // (FF00+C) <- A
    ACT_ST_HL   = 4'd6,   // (HL) <- A
    ACT_ST_HN   = 4'd7,   // (FF00+n) <- A
    ACT_LD_A_HN = 4'd8,   // A <- (FF00+n)
    ACT_LD_A_DE = 4'd9,   // A <- (DE)
    ACT_ST_NN   = 4'd10,  // (nn) <- A
    ACT_RD_RET  = 4'd11   // read return
  } act_e;

  // Update kinds on the result channel
  typedef enum logic [2:0] {
    KIND_REG8 = 3'd0,
    KIND_PAIR = 3'd1,
    KIND_MEMW = 3'd2,
    KIND_MEMR = 3'd3,
    KIND_PC   = 3'd4
  } kind_e;

  // 8-bit register indexes
  localparam logic [2:0] REG_A = 3'd0;
  localparam logic [2:0] REG_B = 3'd1;
  localparam logic [2:0] REG_C = 3'd2;
  localparam logic [2:0] REG_D = 3'd3;
  localparam logic [2:0] REG_E = 3'd4;
  localparam logic [2:0] REG_H = 3'd5;
  localparam logic [2:0] REG_L = 3'd6;
  localparam logic [2:0] REG_NONE = 3'd7;

  // Pair indexes
  localparam logic [2:0] PAIR_DE = 3'd0;
  localparam logic [2:0] PAIR_HL = 3'd1;
  localparam logic [2:0] PAIR_SP = 3'd2;

  // Register file rows: B:C, D:E, H:L; the last row is never written
  localparam int unsigned NUM_ROWS = 4;
  localparam logic [1:0] ROW_BC   = 2'd0;
  localparam logic [1:0] ROW_DE   = 2'd1;
  localparam logic [1:0] ROW_HL   = 2'd2;
  localparam logic [1:0] ROW_NONE = 2'd3;

  localparam logic [15:0] HIGH_PAGE = 16'hFF00;

  // Field widths
  localparam int unsigned ACT_W  = 4;
  localparam int unsigned SEL_W  = 3;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned KIND_W = 3;

  // Input beat as held in the execute stage
  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [SEL_W-1:0]  dest_sel;
    logic [SEL_W-1:0]  src_sel;
    logic [WORD_W-1:0] imm_word;
    logic [BYTE_W-1:0] read_data;
  } req_t;

  // Result beat
  typedef struct packed {
    kind_e             kind;
    logic [SEL_W-1:0]  target;
    logic [WORD_W-1:0] addr;
    logic [WORD_W-1:0] value;
    logic              last;
  } upd_t;

  // Row of the register file that holds an 8-bit register
  function automatic logic [1:0] sel_row(input logic [SEL_W-1:0] sel);
    logic [1:0] row;
    unique case (sel)
      REG_B, REG_C: row = ROW_BC;
      REG_D, REG_E: row = ROW_DE;
      REG_H, REG_L: row = ROW_HL;
      default:      row = ROW_NONE;
    endcase
    return row;
  endfunction

  function automatic upd_t mk_upd(input kind_e kind, input logic [SEL_W-1:0] target,
                                  input logic [WORD_W-1:0] addr,
                                  input logic [WORD_W-1:0] value);
    upd_t u;
    u.kind   = kind;
    u.target = target;
    u.addr   = addr;
    u.value  = value;
    u.last   = 1'b0;
    return u;
  endfunction

endpackage

`default_nettype wire

// ===== src/ldx_req_if.sv =====
// Input channel of the load executor: valid/ready plus one decoded load.
// Depends on ldx_pkg for field widths.
`default_nettype none

interface ldx_req_if;
  import ldx_pkg::*;

  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [SEL_W-1:0]  dest_sel;
  logic [SEL_W-1:0]  src_sel;
  logic [WORD_W-1:0] imm_word;
  logic [BYTE_W-1:0] read_data;

  modport source (
    output valid, action, dest_sel, src_sel, imm_word, read_data,
    input  ready
  );

  modport sink (
    input  valid, action, dest_sel, src_sel, imm_word, read_data,
    output ready
  );

endinterface

`default_nettype wire

// ===== src/ldx_upd_if.sv =====
// Result channel of the load executor: valid/ready plus one update beat.
// Depends on ldx_pkg for field widths.
`default_nettype none

interface ldx_upd_if;
  import ldx_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] update_kind;
  logic [SEL_W-1:0]  target;
  logic [WORD_W-1:0] addr;
  logic [WORD_W-1:0] value;
  logic              last;

  modport source (
    output valid, update_kind, target, addr, value, last,
    input  ready
  );

  modport sink (
    input  valid, update_kind, target, addr, value, last,
    output ready
  );

endinterface

`default_nettype wire

// ===== src/cpu_load_instruction_executor.sv =====
// An accepted load waits in the execute stage until the three-entry result queue is
// empty or its last beat is leaving, then loads its zero to three update beats, and a
// new load is accepted as it moves on; the queue drains one beat per cycle on upd.ready.
// B:C, D:E, H:L sit in a 4x16 register file (byte lanes, registered read); A, PC and
// the pending-read flag are flops. Reset is immediate: per-lane valid bits make the
// register file read as zero until written. Depends on ldx_pkg, ldx_req_if, ldx_upd_if.
`default_nettype none

module cpu_load_instruction_executor (
  input  logic       clk_i,
  input  logic       rst_ni,
  ldx_req_if.sink    req,
  ldx_upd_if.source  upd
);
  import ldx_pkg::*;

  // Register file: two byte lanes, one read and one write port
  logic [BYTE_W-1:0]   mem_hi [NUM_ROWS];
  logic [BYTE_W-1:0]   mem_lo [NUM_ROWS];
  logic [NUM_ROWS-1:0] vld_hi_q, vld_lo_q;

  logic [BYTE_W-1:0] rd_hi_q, rd_lo_q;
  logic              rvld_hi_q, rvld_lo_q;
  logic              byp_hi_q, byp_lo_q;
  logic [BYTE_W-1:0] byp_hi_dat_q, byp_lo_dat_q;

  // Execute stage and architectural flops
  req_t              ex_q;
  logic              ex_vld_q;
  logic [BYTE_W-1:0] a_q, a_d;
  logic [WORD_W-1:0] pc_q, pc_d;
  logic              pend_q, pend_d;

  // Result queue, head at entry 0
  upd_t       oq_q [3];
  logic [1:0] cnt_q;

  logic       in_fire, out_fire, ex_fire;
  logic [1:0] rd_row;

  // Write port
  logic              mem_we, be_hi, be_lo;
  logic [1:0]        wr_row;
  logic [WORD_W-1:0] wdata;

  // Execute-stage combinational values
  act_e              ex_act;
  logic [BYTE_W-1:0] n8, ex_hi, ex_lo, src_b;
  logic [WORD_W-1:0] row_w, nhl;
  upd_t              pre [2];
  upd_t              pc_rec;
  upd_t              lst [3];
  logic [1:0]        npre, n_res, step;
  logic              has_pc;

  // Handshakes
  assign out_fire  = upd.valid && upd.ready;
  assign ex_fire   = ex_vld_q && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && upd.ready));
  assign req.ready = !ex_vld_q || ex_fire;
  assign in_fire   = req.valid && req.ready;

  // Read row chosen at accept
  always_comb begin
    unique case (act_e'(req.action))
      ACT_LD_R_R:                        rd_row = sel_row(req.src_sel);
      ACT_ST_HLD, ACT_ST_HLI, ACT_ST_HL: rd_row = ROW_HL;
      ACT_ST_HC:                         rd_row = ROW_BC;
      ACT_LD_A_DE:                       rd_row = ROW_DE;
      default:                           rd_row = ROW_HL;
    endcase
  end

  // Register file array: write back and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      if (be_hi) mem_hi[wr_row] <= wdata[15:8];
      if (be_lo) mem_lo[wr_row] <= wdata[7:0];
    end
    if (in_fire) begin
      rd_hi_q      <= mem_hi[rd_row];
      rd_lo_q      <= mem_lo[rd_row];
      rvld_hi_q    <= vld_hi_q[rd_row];
      rvld_lo_q    <= vld_lo_q[rd_row];
      // same-cycle write to the row being read: forward it
      byp_hi_q     <= mem_we && be_hi && (wr_row == rd_row);
      byp_lo_q     <= mem_we && be_lo && (wr_row == rd_row);
      byp_hi_dat_q <= wdata[15:8];
      byp_lo_dat_q <= wdata[7:0];
    end
  end

  // Lane valid bits: unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_hi_q <= '0;
      vld_lo_q <= '0;
    end else if (mem_we) begin
      if (be_hi) vld_hi_q[wr_row] <= 1'b1;
      if (be_lo) vld_lo_q[wr_row] <= 1'b1;
    end
  end

  // Execute: decode the held load into up to three update beats
  always_comb begin
    ex_act = act_e'(ex_q.action);
    n8     = ex_q.imm_word[7:0];
    ex_hi  = byp_hi_q ? byp_hi_dat_q : (rvld_hi_q ? rd_hi_q : '0);
    ex_lo  = byp_lo_q ? byp_lo_dat_q : (rvld_lo_q ? rd_lo_q : '0);
    row_w  = {ex_hi, ex_lo};
    nhl    = (ex_act == ACT_ST_HLD) ? row_w - 16'd1 : row_w + 16'd1;

    // source byte of a register move; select seven reads as zero
    if (ex_q.src_sel == REG_A) begin
      src_b = a_q;
    end else if (ex_q.src_sel == REG_NONE) begin
      src_b = '0;
    end else begin
      src_b = ex_q.src_sel[0] ? ex_hi : ex_lo;
    end

    pre[0] = '0;
    pre[1] = '0;
    npre   = 2'd0;
    has_pc = 1'b0;
    step   = 2'd0;
    mem_we = 1'b0;
    be_hi  = 1'b0;
    be_lo  = 1'b0;
    wr_row = ROW_HL;
    wdata  = ex_q.imm_word;
    a_d    = a_q;
    pend_d = pend_q;

    unique case (ex_act)
      ACT_LD_PAIR: begin
        has_pc = 1'b1;
        step   = 2'd3;
        priority if (ex_q.dest_sel == PAIR_DE) begin
          mem_we = 1'b1; be_hi = 1'b1; be_lo = 1'b1; wr_row = ROW_DE;
          pre[0] = mk_upd(KIND_PAIR, PAIR_DE, '0, ex_q.imm_word);
          npre   = 2'd1;
        end else if (ex_q.dest_sel == PAIR_HL) begin
          mem_we = 1'b1; be_hi = 1'b1; be_lo = 1'b1; wr_row = ROW_HL;
          pre[0] = mk_upd(KIND_PAIR, PAIR_HL, '0, ex_q.imm_word);
          npre   = 2'd1;
        end else if (ex_q.dest_sel == PAIR_SP) begin
          // SP is never read by this group: the beat carries its new value
          pre[0] = mk_upd(KIND_PAIR, PAIR_SP, '0, ex_q.imm_word);
          npre   = 2'd1;
        end else begin
          // pair select above SP: PC beat only
          npre   = 2'd0;
        end
      end
      ACT_LD_R_N, ACT_LD_R_R: begin
        has_pc = 1'b1;
        step   = (ex_act == ACT_LD_R_N) ? 2'd2 : 2'd1;
        wdata  = (ex_act == ACT_LD_R_N) ? {n8, n8} : {src_b, src_b};
        if (ex_q.dest_sel != REG_NONE) begin
          pre[0] = mk_upd(KIND_REG8, ex_q.dest_sel, '0, {8'd0, wdata[7:0]});
          npre   = 2'd1;
          if (ex_q.dest_sel == REG_A) begin
            a_d = wdata[7:0];
          end else begin
            mem_we = 1'b1;
            wr_row = sel_row(ex_q.dest_sel);
            be_hi  = ex_q.dest_sel[0];
            be_lo  = !ex_q.dest_sel[0];
          end
        end
      end
      ACT_ST_HLD, ACT_ST_HLI: begin
        has_pc = 1'b1;
        step   = 2'd1;
        mem_we = 1'b1; be_hi = 1'b1; be_lo = 1'b1; wr_row = ROW_HL;
        wdata  = nhl;
        pre[0] = mk_upd(KIND_MEMW, '0, row_w, {8'd0, a_q});
        pre[1] = mk_upd(KIND_PAIR, PAIR_HL, '0, nhl);
        npre   = 2'd2;
      end
      ACT_ST_HC: begin
        has_pc = 1'b1;
        step   = 2'd1;
        pre[0] = mk_upd(KIND_MEMW, '0, HIGH_PAGE | {8'd0, ex_lo}, {8'd0, a_q});
        npre   = 2'd1;
      end
      ACT_ST_HL: begin
        has_pc = 1'b1;
        step   = 2'd1;
        pre[0] = mk_upd(KIND_MEMW, '0, row_w, {8'd0, a_q});
        npre   = 2'd1;
      end
      ACT_ST_HN: begin
        has_pc = 1'b1;
        step   = 2'd2;
        pre[0] = mk_upd(KIND_MEMW, '0, HIGH_PAGE | {8'd0, n8}, {8'd0, a_q});
        npre   = 2'd1;
      end
      ACT_LD_A_HN: begin
        has_pc = 1'b1;
        step   = 2'd2;
        pend_d = 1'b1;
        pre[0] = mk_upd(KIND_MEMR, '0, HIGH_PAGE | {8'd0, n8}, '0);
        npre   = 2'd1;
      end
      ACT_LD_A_DE: begin
        has_pc = 1'b1;
        step   = 2'd1;
        pend_d = 1'b1;
        pre[0] = mk_upd(KIND_MEMR, '0, row_w, '0);
        npre   = 2'd1;
      end
      ACT_ST_NN: begin
        has_pc = 1'b1;
        step   = 2'd3;
        pre[0] = mk_upd(KIND_MEMW, '0, ex_q.imm_word, {8'd0, a_q});
        npre   = 2'd1;
      end
      ACT_RD_RET: begin
        // a return with nothing pending is dropped
        if (pend_q) begin
          a_d    = ex_q.read_data;
          pend_d = 1'b0;
          pre[0] = mk_upd(KIND_REG8, REG_A, '0, {8'd0, ex_q.read_data});
          npre   = 2'd1;
        end
      end
      default: ;
    endcase

    // PC beat, when present, closes the list
    pc_d   = pc_q + {14'd0, step};
    pc_rec = mk_upd(KIND_PC, '0, '0, pc_d);
    lst[0] = (npre != 2'd0) ? pre[0] : pc_rec;
    lst[1] = (npre == 2'd2) ? pre[1] : pc_rec;
    lst[2] = pc_rec;
    n_res  = npre + {1'b0, has_pc};
    unique case (n_res)
      2'd1:    lst[0].last = 1'b1;
      2'd2:    lst[1].last = 1'b1;
      2'd3:    lst[2].last = 1'b1;
      default: ;
    endcase

    // state commits only when the beats are loaded
    if (!ex_fire) begin
      mem_we = 1'b0;
    end
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_vld_q <= 1'b0;
      cnt_q    <= 2'd0;
      a_q      <= '0;
      pc_q     <= '0;
      pend_q   <= 1'b0;
    end else begin
      if (in_fire) begin
        ex_vld_q <= 1'b1;
      end else if (ex_fire) begin
        ex_vld_q <= 1'b0;
      end
      if (ex_fire) begin
        cnt_q  <= n_res;
        a_q    <= a_d;
        pend_q <= pend_d;
        if (has_pc) pc_q <= pc_d;
      end else if (out_fire) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  // Execute-stage payload and result queue
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ex_q.action    <= req.action;
      ex_q.dest_sel  <= req.dest_sel;
      ex_q.src_sel   <= req.src_sel;
      ex_q.imm_word  <= req.imm_word;
      ex_q.read_data <= req.read_data;
    end
    if (ex_fire) begin
      oq_q[0] <= lst[0];
      oq_q[1] <= lst[1];
      oq_q[2] <= lst[2];
    end else if (out_fire) begin
      oq_q[0] <= oq_q[1];
      oq_q[1] <= oq_q[2];
    end
  end

  // Result channel
  assign upd.valid       = (cnt_q != 2'd0);
  assign upd.update_kind = oq_q[0].kind;
  assign upd.target      = oq_q[0].target;
  assign upd.addr        = oq_q[0].addr;
  assign upd.value       = oq_q[0].value;
  assign upd.last        = oq_q[0].last;

  // Checks
  a_beats_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex_fire && (n_res != 2'd0) |=> upd.valid)
    else $error("loaded beats not presented");

  a_no_spare_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (wr_row != ROW_NONE))
    else $error("write to unused register row");

  a_read_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex_fire && (ex_act == ACT_LD_A_HN || ex_act == ACT_LD_A_DE) |=> pend_q)
    else $error("read request did not set pending");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !ex_fire |=> (cnt_q == $past(cnt_q) - 2'd1))
    else $error("queue count off after a beat");

  a_accept_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> ex_vld_q)
    else $error("accepted load lost");

endmodule

`default_nettype wire

// ===== verif/cpu_load_instruction_executor_test.sv =====
// Testbench for cpu_load_instruction_executor: random and directed loads,
// an in-bench model of the register state, and beat-by-beat checks of the update stream.
// Depends on ldx_pkg, ldx_req_if, ldx_upd_if and the RTL of the block.
`timescale 1ns / 100ps

module cpu_load_instruction_executor_test;
  import ldx_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 12;
  localparam int TOTAL_LOADS    = 220;
  localparam int PHASE_LEN      = 30;
  localparam int IDLE_HEAVY_PCT = 85;
  localparam int IDLE_LIGHT_PCT = 7;
  localparam int STALL_LIMIT    = 2000;
  localparam int DRAIN_CYCLES   = 20;

  // First of the four action codes that the block ignores
  localparam logic [3:0] ACT_UNUSED_FIRST = 4'd12;

  typedef enum logic [1:0] {
    PH_STEADY, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH_IDLE
  } idle_phase_e;

  typedef struct {
    logic [3:0]  action;
    logic [2:0]  dest;
    logic [2:0]  src;
    logic [15:0] imm;
    logic [7:0]  rdata;
  } load_t;

  typedef struct {
    kind_e       kind;
    logic [2:0]  target;
    logic [15:0] addr;
    logic [15:0] value;
    logic        last;
  } update_t;

  logic clk = 1'b0;
  logic rst_n;

  ldx_req_if req_ch ();
  ldx_upd_if upd_ch ();

  cpu_load_instruction_executor DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req    (req_ch),
    .upd    (upd_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // CPU state as the block should hold it
  logic [7:0]  regfile [0:6];
  logic [15:0] sp_model;
  logic [15:0] pc_model;
  logic        read_outstanding;

  load_t   load_backlog [$];
  update_t expected_updates [$];
  load_t   driven_load;
  int      loads_queued;
  int      loads_accepted;
  int      error_count;
  int      idle_cycles;

  function automatic update_t beat(input kind_e k, input logic [2:0] t,
                                   input logic [15:0] a, input logic [15:0] v);
    update_t u;
    u.kind   = k;
    u.target = t;
    u.addr   = a;
    u.value  = v;
    u.last   = 1'b0;
    return u;
  endfunction

  function automatic update_t pc_beat(input logic [15:0] step);
    pc_model = pc_model + step;
    return beat(KIND_PC, 3'd0, 16'd0, pc_model);
  endfunction

  // Apply one load to the state model and queue the beats it should produce
  task automatic execute_load(input load_t ld);
    update_t     beats [$];
    logic [7:0]  acc;
    logic [7:0]  n8;
    logic [7:0]  mv;
    logic [15:0] hl;
    logic [15:0] nhl;
    acc = regfile[REG_A];
    n8  = ld.imm[7:0];
    hl  = {regfile[REG_H], regfile[REG_L]};
    case (ld.action)
      ACT_LD_PAIR: begin
        if (ld.dest == PAIR_DE) begin
          regfile[REG_D] = ld.imm[15:8];
          regfile[REG_E] = n8;
        end else if (ld.dest == PAIR_HL) begin
          regfile[REG_H] = ld.imm[15:8];
          regfile[REG_L] = n8;
        end else if (ld.dest == PAIR_SP) begin
          sp_model = ld.imm;
        end
        // pair select above SP: only the PC moves
        if (ld.dest <= PAIR_SP) beats.push_back(beat(KIND_PAIR, ld.dest, 16'd0, ld.imm));
        beats.push_back(pc_beat(16'd3));
      end
      ACT_LD_R_N: begin
        if (ld.dest != REG_NONE) begin
          regfile[ld.dest] = n8;
          beats.push_back(beat(KIND_REG8, ld.dest, 16'd0, {8'd0, n8}));
        end
        beats.push_back(pc_beat(16'd2));
      end
      ACT_LD_R_R: begin
        mv = (ld.src != REG_NONE) ? regfile[ld.src] : 8'd0;
        if (ld.dest != REG_NONE) begin
          regfile[ld.dest] = mv;
          beats.push_back(beat(KIND_REG8, ld.dest, 16'd0, {8'd0, mv}));
        end
        beats.push_back(pc_beat(16'd1));
      end
      ACT_ST_HLD, ACT_ST_HLI: begin
        nhl = (ld.action == ACT_ST_HLD) ? hl - 16'd1 : hl + 16'd1;
        beats.push_back(beat(KIND_MEMW, 3'd0, hl, {8'd0, acc}));
        regfile[REG_H] = nhl[15:8];
        regfile[REG_L] = nhl[7:0];
        beats.push_back(beat(KIND_PAIR, PAIR_HL, 16'd0, nhl));
        beats.push_back(pc_beat(16'd1));
      end
      ACT_ST_HC: begin
        beats.push_back(beat(KIND_MEMW, 3'd0, HIGH_PAGE + {8'd0, regfile[REG_C]},
                             {8'd0, acc}));
        beats.push_back(pc_beat(16'd1));
      end
      ACT_ST_HL: begin
        beats.push_back(beat(KIND_MEMW, 3'd0, hl, {8'd0, acc}));
        beats.push_back(pc_beat(16'd1));
      end
      ACT_ST_HN: begin
        beats.push_back(beat(KIND_MEMW, 3'd0, HIGH_PAGE + {8'd0, n8}, {8'd0, acc}));
        beats.push_back(pc_beat(16'd2));
      end
      ACT_LD_A_HN: begin
        beats.push_back(beat(KIND_MEMR, 3'd0, HIGH_PAGE + {8'd0, n8}, 16'd0));
        read_outstanding = 1'b1;
        beats.push_back(pc_beat(16'd2));
      end
      ACT_LD_A_DE: begin
        beats.push_back(beat(KIND_MEMR, 3'd0, {regfile[REG_D], regfile[REG_E]}, 16'd0));
        read_outstanding = 1'b1;
        beats.push_back(pc_beat(16'd1));
      end
      ACT_ST_NN: begin
        beats.push_back(beat(KIND_MEMW, 3'd0, ld.imm, {8'd0, acc}));
        beats.push_back(pc_beat(16'd3));
      end
      ACT_RD_RET: begin
        // a return with no read outstanding is dropped
        if (read_outstanding) begin
          regfile[REG_A] = ld.rdata;
          read_outstanding = 1'b0;
          beats.push_back(beat(KIND_REG8, REG_A, 16'd0, {8'd0, ld.rdata}));
        end
      end
      default: ;
    endcase
    if (beats.size() != 0) beats[beats.size() - 1].last = 1'b1;
    foreach (beats[i]) expected_updates.push_back(beats[i]);
  endtask

  // Stimulus queue
  task automatic queue_load(input logic [3:0] act, input logic [2:0] dest,
                            input logic [2:0] src, input logic [15:0] imm,
                            input logic [7:0] rdata);
    load_t ld;
    ld.action = act;
    ld.dest   = dest;
    ld.src    = src;
    ld.imm    = imm;
    ld.rdata  = rdata;
    load_backlog.push_back(ld);
    loads_queued++;
  endtask

  task automatic add_random_load();
    logic [2:0]  dest;
    logic [2:0]  src;
    logic [15:0] imm;
    logic [3:0]  act;
    int          pick;
    dest = ($urandom_range(0, 9) == 0) ? REG_NONE : 3'($urandom_range(0, 6));
    src  = ($urandom_range(0, 9) == 0) ? REG_NONE : 3'($urandom_range(0, 6));
    case ($urandom_range(0, 9))
      0:       imm = 16'h0000;
      1:       imm = 16'hFFFF;
      default: imm = 16'($urandom);
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      // read request followed by its return
      act = $urandom_range(0, 1) ? ACT_LD_A_HN : ACT_LD_A_DE;
      queue_load(act, dest, src, imm, 8'($urandom));
      queue_load(ACT_RD_RET, dest, src, imm, 8'($urandom));
    end else if (pick < 17) begin
      // noise: stray return or unused code
      act = $urandom_range(0, 1) ? ACT_RD_RET : 4'(ACT_UNUSED_FIRST + $urandom_range(0, 3));
      queue_load(act, dest, src, imm, 8'($urandom));
    end else begin
      act = 4'($urandom_range(ACT_LD_PAIR, ACT_ST_NN));
      if (act == ACT_LD_PAIR)
        dest = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(3, 7)) : 3'($urandom_range(0, 2));
      queue_load(act, dest, src, imm, 8'($urandom));
    end
  endtask

  function automatic idle_phase_e current_phase();
    return idle_phase_e'((loads_accepted / PHASE_LEN) % 4);
  endfunction

  function automatic int idle_pct(input bit recv_side);
    case (current_phase())
      PH_SEND_IDLE:  return recv_side ? 0 : IDLE_HEAVY_PCT;
      PH_RECV_STALL: return recv_side ? IDLE_HEAVY_PCT : 0;
      PH_BOTH_IDLE:  return IDLE_LIGHT_PCT;
      default:       return 0;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  // Driver: predicts on each accepted beat, then presents the next load
  always @(posedge clk) begin : load_driver
    if (rst_n) begin
      if (req_ch.valid && req_ch.ready) begin
        execute_load(driven_load);
        loads_accepted++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (load_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
          driven_load = load_backlog.pop_front();
          req_ch.action    <= driven_load.action;
          req_ch.dest_sel  <= driven_load.dest;
          req_ch.src_sel   <= driven_load.src;
          req_ch.imm_word  <= driven_load.imm;
          req_ch.read_data <= driven_load.rdata;
          req_ch.valid     <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result side back-pressure
  always @(posedge clk) begin : update_ready
    if (!rst_n) begin
      upd_ch.ready <= 1'b0;
    end else begin
      upd_ch.ready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
    end
  end

  // Monitor: each accepted update beat against the oldest expectation
  always @(posedge clk) begin : update_monitor
    update_t want;
    if (rst_n && upd_ch.valid && upd_ch.ready) begin
      if (expected_updates.size() == 0) begin
        $error("unexpected update beat: kind %0d target %0d addr 0x%0h value 0x%0h",
               upd_ch.update_kind, upd_ch.target, upd_ch.addr, upd_ch.value);
        error_count++;
      end else begin
        want = expected_updates.pop_front();
        check_field("update_kind", 16'(want.kind), 16'(upd_ch.update_kind));
        check_field("target", 16'(want.target), 16'(upd_ch.target));
        check_field("addr", want.addr, upd_ch.addr);
        check_field("value", want.value, upd_ch.value);
        check_field("last", 16'(want.last), 16'(upd_ch.last));
      end
    end
  end

  // Watchdog: no beat on either channel for too long
  always @(posedge clk) begin : watchdog
    if ((req_ch.valid && req_ch.ready) || (upd_ch.valid && upd_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.action    = '0;
    req_ch.dest_sel  = '0;
    req_ch.src_sel   = '0;
    req_ch.imm_word  = '0;
    req_ch.read_data = '0;
    upd_ch.ready     = 1'b0;
    foreach (regfile[i]) regfile[i] = 8'd0;
    sp_model         = 16'd0;
    pc_model         = 16'd0;
    read_outstanding = 1'b0;
    loads_queued     = 0;
    loads_accepted   = 0;
    error_count      = 0;
    idle_cycles      = 0;

    // Directed: HL wrap both ways, pair selects DE, HL, SP and one above SP, select seven,
    // low byte of imm, high page corners, stray and doubled reads, unused codes
    queue_load(ACT_LD_PAIR, PAIR_DE, REG_A, 16'hFFFF, 8'h00);
    queue_load(ACT_LD_PAIR, PAIR_HL, REG_A, 16'h0000, 8'h00);
    queue_load(ACT_ST_HLD, REG_A, REG_A, 16'h0000, 8'h00);
    queue_load(ACT_ST_HLI, REG_A, REG_A, 16'h0000, 8'h00);
    queue_load(ACT_LD_PAIR, PAIR_SP, REG_A, 16'hFFFF, 8'h00);
    queue_load(ACT_LD_PAIR, REG_NONE, REG_A, 16'h1234, 8'h00);
    queue_load(ACT_LD_R_N, REG_A, REG_A, 16'h12FF, 8'h00);
    queue_load(ACT_LD_R_N, REG_NONE, REG_A, 16'h00AB, 8'h00);
    queue_load(ACT_LD_R_R, REG_B, REG_A, 16'h0000, 8'h00);
    queue_load(ACT_LD_R_R, REG_C, REG_NONE, 16'h0000, 8'h00);
    queue_load(ACT_LD_R_R, REG_NONE, REG_B, 16'h0000, 8'h00);
    queue_load(ACT_LD_R_N, REG_C, REG_A, 16'h00FF, 8'h00);
    queue_load(ACT_ST_HC, REG_A, REG_A, 16'h0000, 8'h00);
    queue_load(ACT_ST_HL, REG_A, REG_A, 16'h0000, 8'h00);
    queue_load(ACT_ST_HN, REG_A, REG_A, 16'hFF00, 8'h00);
    queue_load(ACT_ST_HN, REG_A, REG_A, 16'h00FF, 8'h00);
    queue_load(ACT_LD_A_HN, REG_A, REG_A, 16'hABFF, 8'h00);
    queue_load(ACT_RD_RET, REG_A, REG_A, 16'h0000, 8'hFF);
    queue_load(ACT_RD_RET, REG_A, REG_A, 16'h0000, 8'h55);
    queue_load(ACT_LD_A_DE, REG_A, REG_A, 16'h0000, 8'h00);
    queue_load(ACT_LD_A_HN, REG_A, REG_A, 16'h0000, 8'h00);
    queue_load(ACT_RD_RET, REG_A, REG_A, 16'h0000, 8'h00);
    queue_load(ACT_ST_NN, REG_A, REG_A, 16'hFFFF, 8'h00);
    queue_load(ACT_ST_NN, REG_A, REG_A, 16'h0000, 8'h00);
    queue_load(ACT_UNUSED_FIRST, REG_NONE, REG_NONE, 16'hFFFF, 8'hFF);
    queue_load(4'(ACT_UNUSED_FIRST + 3), REG_A, REG_A, 16'h0000, 8'h00);

    // Random part fills up to the total load count
    while (loads_queued < TOTAL_LOADS) add_random_load();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (loads_accepted != loads_queued) @(posedge clk);
    while (expected_updates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
